// ===== rtl/dxt_block_decoder_assert.svh =====
// Assertion macros for the block decoder.
// Used by the top level only; needs nothing else.
`ifndef DXT_BLOCK_DECODER_ASSERT_SVH
`define DXT_BLOCK_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DXT_ASSERT_IMPLY(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DXT_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ===== rtl/dxtbd_pkg.sv =====
// Shared types and constants for the block decoder.
// No dependencies.
package dxtbd_pkg;

    // Texture format codes held in the configuration register.
    typedef enum logic [1:0] {
        FMT_DXT1  = 2'd0,
        FMT_DXT3  = 2'd1,
        FMT_DXT5  = 2'd2,
        FMT_OTHER = 2'd3
    } t_fmt;

    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
    localparam logic [3:0] LAST_PIXEL   = 4'd15;

    // Per-block lookup tables: four colour entries and eight alpha entries.
    typedef struct packed {
        logic [3:0][7:0] red;
        logic [3:0][7:0] green;
        logic [3:0][7:0] blue;
        logic [3:0][7:0] calpha;
        logic [7:0][7:0] atab;
    } t_tables;

endpackage

// ===== rtl/dxtbd_if.sv =====
// Valid/ready channel interfaces for compressed blocks and decoded pixels.
// No dependencies.
interface dxtbd_block_if;
    logic        valid;
    logic        ready;
    logic [63:0] alpha_word;
    logic [63:0] color_word;

    modport source (output valid, output alpha_word, output color_word, input ready);
    modport sink   (input valid, input alpha_word, input color_word, output ready);
endinterface

interface dxtbd_pixel_if;
    logic       valid;
    logic       ready;
    logic [3:0] pixel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last;

    modport source (output valid, output pixel_index, output red, output green,
                    output blue, output alpha, output last, input ready);
    modport sink   (input valid, input pixel_index, input red, input green,
                    input blue, input alpha, input last, output ready);
endinterface

// ===== rtl/dxt_block_decoder.sv =====
// Block decoder: one compressed 4x4 block in, sixteen RGBA pixel beats out.
// A block passes the input stage, the table stage and the output register in turn.
// Pixels are emitted one per cycle while the output channel is ready; a new block is
// taken while the previous one is still being emitted.
// Reset (synchronous, active low) empties all stages and sets the format to DXT1.
module dxt_block_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_data,
    dxtbd_block_if.sink         i_blk,
    dxtbd_pixel_if.source       o_pix
);
    import dxtbd_pkg::*;

    `include "dxt_block_decoder_assert.svh"

    // Configuration.
    t_fmt        r_fmt, n_fmt;

    // Input stage: one buffered block.
    logic        r_a_vld, n_a_vld;
    logic [63:0] r_a_aw, n_a_aw;
    logic [63:0] r_a_cw, n_a_cw;

    // Table stage: the block being emitted, one pixel per beat.
    logic        r_b_vld, n_b_vld;
    t_tables     r_b_tab, n_b_tab;
    logic [31:0] r_b_idx, n_b_idx;
    logic [63:0] r_b_aw, n_b_aw;
    t_fmt        r_b_fmt, n_b_fmt;
    logic [3:0]  r_b_cnt, n_b_cnt;

    // Output register.
    logic        r_o_vld, n_o_vld;
    logic [3:0]  r_o_idx, n_o_idx;
    logic [7:0]  r_o_red, n_o_red;
    logic [7:0]  r_o_grn, n_o_grn;
    logic [7:0]  r_o_blu, n_o_blu;
    logic [7:0]  r_o_alp, n_o_alp;
    logic        r_o_last, n_o_last;

    t_tables     w_tab;
    logic        w_o_free;
    logic        w_b_fire;
    logic        w_b_done;
    logic        w_a_move;
    logic        w_in_acc;
    logic [1:0]  w_ci;
    logic [3:0]  w_nib;
    logic [5:0]  w_apos;
    logic [2:0]  w_aidx;
    logic [7:0]  w_alpha;

    dxtbd_table_gen u_table_gen (
        .i_alpha_word (r_a_aw),
        .i_color_word (r_a_cw),
        .i_fmt        (r_fmt),
        .o_tab        (w_tab)
    );

    // Handshake between the stages.
    assign w_o_free = !r_o_vld || o_pix.ready;
    assign w_b_fire = r_b_vld && w_o_free;
    assign w_b_done = w_b_fire && (r_b_cnt == LAST_PIXEL);
    assign w_a_move = r_a_vld && (!r_b_vld || w_b_done);
    assign i_blk.ready = !r_a_vld || w_a_move;
    assign w_in_acc = i_blk.valid && i_blk.ready;

    // Per-pixel selection from the stored tables.
    assign w_ci   = r_b_idx[{r_b_cnt, 1'b0} +: 2];
    assign w_nib  = r_b_aw[{r_b_cnt, 2'b00} +: 4];
    assign w_apos = 6'({r_b_cnt, 1'b0}) + 6'(r_b_cnt) + 6'd16;
    assign w_aidx = r_b_aw[w_apos +: 3];

    always_comb begin
        case (r_b_fmt)
            FMT_DXT1: w_alpha = r_b_tab.calpha[w_ci];
            FMT_DXT3: w_alpha = {w_nib, w_nib};
            FMT_DXT5: w_alpha = r_b_tab.atab[w_aidx];
            default:  w_alpha = ALPHA_OPAQUE;
        endcase
    end

    // Next-state logic for all stages.
    always_comb begin
        n_fmt    = i_cfg_we ? t_fmt'(i_cfg_data) : r_fmt;

        n_a_vld  = w_in_acc || (r_a_vld && !w_a_move);
        n_a_aw   = w_in_acc ? i_blk.alpha_word : r_a_aw;
        n_a_cw   = w_in_acc ? i_blk.color_word : r_a_cw;

        n_b_vld  = w_a_move || (r_b_vld && !w_b_done);
        n_b_tab  = w_a_move ? w_tab : r_b_tab;
        n_b_idx  = w_a_move ? r_a_cw[63:32] : r_b_idx;
        n_b_aw   = w_a_move ? r_a_aw : r_b_aw;
        n_b_fmt  = w_a_move ? r_fmt : r_b_fmt;
        if (w_a_move) begin
            n_b_cnt = 4'd0;
        end else if (w_b_fire) begin
            n_b_cnt = r_b_cnt + 4'd1;
        end else begin
            n_b_cnt = r_b_cnt;
        end

        n_o_vld  = w_b_fire || (r_o_vld && !o_pix.ready);
        n_o_idx  = w_b_fire ? r_b_cnt : r_o_idx;
        n_o_red  = w_b_fire ? r_b_tab.red[w_ci] : r_o_red;
        n_o_grn  = w_b_fire ? r_b_tab.green[w_ci] : r_o_grn;
        n_o_blu  = w_b_fire ? r_b_tab.blue[w_ci] : r_o_blu;
        n_o_alp  = w_b_fire ? w_alpha : r_o_alp;
        n_o_last = w_b_fire ? (r_b_cnt == LAST_PIXEL) : r_o_last;
    end

    // Control registers, cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt   <= FMT_DXT1;
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_b_cnt <= 4'd0;
            r_o_vld <= 1'b0;
        end else begin
            r_fmt   <= n_fmt;
            r_a_vld <= n_a_vld;
            r_b_vld <= n_b_vld;
            r_b_cnt <= n_b_cnt;
            r_o_vld <= n_o_vld;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_a_aw   <= n_a_aw;
        r_a_cw   <= n_a_cw;
        r_b_tab  <= n_b_tab;
        r_b_idx  <= n_b_idx;
        r_b_aw   <= n_b_aw;
        r_b_fmt  <= n_b_fmt;
        r_o_idx  <= n_o_idx;
        r_o_red  <= n_o_red;
        r_o_grn  <= n_o_grn;
        r_o_blu  <= n_o_blu;
        r_o_alp  <= n_o_alp;
        r_o_last <= n_o_last;
    end

    assign o_pix.valid       = r_o_vld;
    assign o_pix.pixel_index = r_o_idx;
    assign o_pix.red         = r_o_red;
    assign o_pix.green       = r_o_grn;
    assign o_pix.blue        = r_o_blu;
    assign o_pix.alpha       = r_o_alp;
    assign o_pix.last        = r_o_last;

    // A running pixel count always belongs to a block in the table stage.
    `DXT_ASSERT_IMPLY(a_cnt_has_block, i_clk, i_rst_n, r_b_cnt != 4'd0, r_b_vld, "pixel count without a block")
    // A block entering the table stage starts at pixel zero.
    `DXT_ASSERT_NEXT(a_block_start, i_clk, i_rst_n, w_a_move, r_b_vld && (r_b_cnt == 4'd0), "block did not start at pixel zero")
    // The last flag marks exactly the final pixel of a block.
    `DXT_ASSERT_IMPLY(a_last_flag, i_clk, i_rst_n, r_o_vld, r_o_last == (r_o_idx == LAST_PIXEL), "last flag out of place")

endmodule

// ===== rtl/dxtbd_table_gen.sv =====
// Builds the colour and alpha lookup tables of one compressed block.
// Depends on dxtbd_pkg.
module dxtbd_table_gen (
    input  logic [63:0]         i_alpha_word,
    input  logic [63:0]         i_color_word,
    input  dxtbd_pkg::t_fmt     i_fmt,
    output dxtbd_pkg::t_tables  o_tab
);
    import dxtbd_pkg::*;

    // Truncating divisions by small constants as reciprocal multiplies.
    // Exact for x below 2048 (by 3), 5461 (by 7) and 16384 (by 5).
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [19:0] p;
        p = {10'd0, x} * 20'd683;
        return p[18:11];
    endfunction

    function automatic logic [7:0] div7(input logic [10:0] x);
        logic [22:0] p;
        p = {12'd0, x} * 23'd2341;
        return p[21:14];
    endfunction

    function automatic logic [7:0] div5(input logic [10:0] x);
        logic [22:0] p;
        p = {12'd0, x} * 23'd3277;
        return p[21:14];
    endfunction

    logic [15:0]      w_c0;
    logic [15:0]      w_c1;
    logic [2:0][7:0]  w_e0;
    logic [2:0][7:0]  w_e1;
    logic             w_four;
    logic [7:0]       w_a0;
    logic [7:0]       w_a1;
    logic [10:0]      w_num7 [1:6];
    logic [10:0]      w_num5 [1:4];

    assign w_c0 = i_color_word[15:0];
    assign w_c1 = i_color_word[31:16];
    assign w_a0 = i_alpha_word[7:0];
    assign w_a1 = i_alpha_word[15:8];

    // Expand the RGB565 endpoints by bit replication.
    assign w_e0[0] = {w_c0[15:11], w_c0[15:13]};
    assign w_e0[1] = {w_c0[10:5],  w_c0[10:9]};
    assign w_e0[2] = {w_c0[4:0],   w_c0[4:2]};
    assign w_e1[0] = {w_c1[15:11], w_c1[15:13]};
    assign w_e1[1] = {w_c1[10:5],  w_c1[10:9]};
    assign w_e1[2] = {w_c1[4:0],   w_c1[4:2]};

    // The three-colour table applies only to DXT1 with c0 not above c1.
    assign w_four = (w_c0 > w_c1) || (i_fmt != FMT_DXT1);

    // Interpolation numerators for the alpha table.
    always_comb begin
        for (int k = 1; k <= 6; k++) begin
            w_num7[k] = 11'(7 - k) * {3'd0, w_a0} + 11'(k) * {3'd0, w_a1};
        end
        for (int k = 1; k <= 4; k++) begin
            w_num5[k] = 11'(5 - k) * {3'd0, w_a0} + 11'(k) * {3'd0, w_a1};
        end
    end

    // Colour table, then the alpha table: sevenths when a0 is above a1,
    // otherwise fifths with fixed ends.
    always_comb begin
        logic [2:0][7:0] v2;
        logic [2:0][7:0] v3;
        for (int c = 0; c < 3; c++) begin
            if (w_four) begin
                v2[c] = div3({1'b0, w_e0[c], 1'b0} + {2'd0, w_e1[c]});
                v3[c] = div3({2'd0, w_e0[c]} + {1'b0, w_e1[c], 1'b0});
            end else begin
                v2[c] = 8'(({1'b0, w_e0[c]} + {1'b0, w_e1[c]}) >> 1);
                v3[c] = 8'd0;
            end
        end
        o_tab.red    = {v3[0], v2[0], w_e1[0], w_e0[0]};
        o_tab.green  = {v3[1], v2[1], w_e1[1], w_e0[1]};
        o_tab.blue   = {v3[2], v2[2], w_e1[2], w_e0[2]};
        o_tab.calpha = {(w_four ? ALPHA_OPAQUE : 8'd0), ALPHA_OPAQUE,
                        ALPHA_OPAQUE, ALPHA_OPAQUE};

        o_tab.atab[0] = w_a0;
        o_tab.atab[1] = w_a1;
        if (w_a0 > w_a1) begin
            for (int k = 1; k <= 6; k++) begin
                o_tab.atab[k + 1] = div7(w_num7[k]);
            end
        end else begin
            for (int k = 1; k <= 4; k++) begin
                o_tab.atab[k + 1] = div5(w_num5[k]);
            end
            o_tab.atab[6] = 8'd0;
            o_tab.atab[7] = ALPHA_OPAQUE;
        end
    end

endmodule

// ===== test/dxt_block_decoder_checker.sv =====
`timescale 1ns / 100ps
// Pixel checker for the block decoder: predicts the sixteen pixels of every accepted
// block and compares them with the pixel beats the decoder emits.
// Depends on dxtbd_pkg for the texture format codes and the opaque alpha value.
module dxt_block_decoder_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_data,
    input  logic        i_blk_valid,
    input  logic        i_blk_ready,
    input  logic [63:0] i_alpha_word,
    input  logic [63:0] i_color_word,
    input  logic        i_pix_valid,
    input  logic        i_pix_ready,
    input  logic [3:0]  i_pixel_index,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic [7:0]  i_alpha,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending
);
    import dxtbd_pkg::*;

    typedef struct packed {
        logic [3:0] pixel_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last;
    } t_pixel;

    t_pixel expected_pixels[$];
    t_fmt   format_q;

    // Bit replication of the 5- and 6-bit endpoint channels up to 8 bits.
    function automatic int unsigned widen5(input logic [4:0] v);
        return {24'd0, v, v[4:2]};
    endfunction

    function automatic int unsigned widen6(input logic [5:0] v);
        return {24'd0, v, v[5:4]};
    endfunction

    // Builds the colour and alpha tables of one block and queues its sixteen pixels.
    task automatic queue_block_pixels(input t_fmt fmt, input logic [63:0] aw,
                                      input logic [63:0] cw);
        logic [15:0] c0;
        logic [15:0] c1;
        int unsigned colors[4][4];
        int unsigned alpha_table[8];
        int unsigned a0;
        int unsigned a1;
        int unsigned ci;
        int unsigned a;
        t_pixel      px;

        c0 = cw[15:0];
        c1 = cw[31:16];
        colors[0][0] = widen5(c0[15:11]);
        colors[0][1] = widen6(c0[10:5]);
        colors[0][2] = widen5(c0[4:0]);
        colors[1][0] = widen5(c1[15:11]);
        colors[1][1] = widen6(c1[10:5]);
        colors[1][2] = widen5(c1[4:0]);
        colors[0][3] = ALPHA_OPAQUE;
        colors[1][3] = ALPHA_OPAQUE;

        // Four-colour table unless DXT1 with c0 <= c1, which gives the three-colour one.
        if (c0 > c1 || fmt != FMT_DXT1) begin
            for (int k = 0; k < 3; k++) begin
                colors[2][k] = (2 * colors[0][k] + colors[1][k]) / 3;
                colors[3][k] = (colors[0][k] + 2 * colors[1][k]) / 3;
            end
            colors[2][3] = ALPHA_OPAQUE;
            colors[3][3] = ALPHA_OPAQUE;
        end else begin
            for (int k = 0; k < 3; k++) begin
                colors[2][k] = (colors[0][k] + colors[1][k]) / 2;
                colors[3][k] = 0;
            end
            colors[2][3] = ALPHA_OPAQUE;
            colors[3][3] = 0;
        end

        // Eight-entry alpha table: sevenths when a0 > a1, else fifths with 0 and 255 ends.
        a0 = aw[7:0];
        a1 = aw[15:8];
        alpha_table[0] = a0;
        alpha_table[1] = a1;
        if (a0 > a1) begin
            for (int k = 1; k <= 6; k++)
                alpha_table[k + 1] = ((7 - k) * a0 + k * a1) / 7;
        end else begin
            for (int k = 1; k <= 4; k++)
                alpha_table[k + 1] = ((5 - k) * a0 + k * a1) / 5;
            alpha_table[6] = 0;
            alpha_table[7] = ALPHA_OPAQUE;
        end

        for (int p = 0; p < 16; p++) begin
            ci = cw[32 + 2 * p +: 2];
            case (fmt)
                FMT_DXT1: a = colors[ci][3];
                FMT_DXT3: a = aw[4 * p +: 4] * 17;
                FMT_DXT5: a = alpha_table[aw[16 + 3 * p +: 3]];
                default:  a = ALPHA_OPAQUE;
            endcase
            px.pixel_index = p[3:0];
            px.red         = colors[ci][0][7:0];
            px.green       = colors[ci][1][7:0];
            px.blue        = colors[ci][2][7:0];
            px.alpha       = a[7:0];
            px.last        = (p == 15);
            expected_pixels.push_back(px);
        end
    endtask

    task automatic check_field(input string field, input int unsigned exp_val,
                               input int unsigned act_val);
        if (exp_val != act_val) begin
            $display("%0t: pixel %s mismatch, expected %0d, actual %0d",
                     $time, field, exp_val, act_val);
            o_fail_count++;
        end
    endtask

    // Track the format, compare each pixel beat with the oldest prediction,
    // then queue the pixels of a block accepted at the same edge.
    always @(posedge i_clk) begin
        t_pixel exp_px;
        if (!i_rst_n) begin
            format_q     = FMT_DXT1;
            o_fail_count = 0;
            expected_pixels.delete();
        end else begin
            if (i_pix_valid && i_pix_ready) begin
                if (expected_pixels.size() == 0) begin
                    $display("%0t: unexpected pixel beat, index %0d", $time, i_pixel_index);
                    o_fail_count++;
                end else begin
                    exp_px = expected_pixels.pop_front();
                    check_field("index", exp_px.pixel_index, i_pixel_index);
                    check_field("red",   exp_px.red,         i_red);
                    check_field("green", exp_px.green,       i_green);
                    check_field("blue",  exp_px.blue,        i_blue);
                    check_field("alpha", exp_px.alpha,       i_alpha);
                    check_field("last",  exp_px.last,        i_last);
                end
            end
            if (i_blk_valid && i_blk_ready)
                queue_block_pixels(format_q, i_alpha_word, i_color_word);
            if (i_cfg_we)
                format_q = t_fmt'(i_cfg_data);
        end
        o_pending = expected_pixels.size();
    end

endmodule

// ===== test/dxt_block_decoder_test.sv =====
`timescale 1ns / 100ps
// Top of the block decoder test: clock, reset, block stimulus, pixel back-pressure
// and the verdict. Depends on dxtbd_pkg, dxtbd_if, dxt_block_decoder and dxt_block_decoder_checker.
module dxt_block_decoder_test;
    import dxtbd_pkg::*;

    typedef enum int {
        RX_ALWAYS,
        RX_MOSTLY,
        RX_RARELY,
        RX_BURSTY
    } t_rx_mode;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       cfg_we;
    logic [1:0] cfg_data;
    int         fail_count;
    int         pending;
    int         burst_left = 0;
    int         gap;

    dxtbd_block_if blk ();
    dxtbd_pixel_if pix ();

    dxt_block_decoder uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_blk      (blk),
        .o_pix      (pix)
    );

    dxt_block_decoder_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_data    (cfg_data),
        .i_blk_valid   (blk.valid),
        .i_blk_ready   (blk.ready),
        .i_alpha_word  (blk.alpha_word),
        .i_color_word  (blk.color_word),
        .i_pix_valid   (pix.valid),
        .i_pix_ready   (pix.ready),
        .i_pixel_index (pix.pixel_index),
        .i_red         (pix.red),
        .i_green       (pix.green),
        .i_blue        (pix.blue),
        .i_alpha       (pix.alpha),
        .i_last        (pix.last),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always #2 i_clk = ~i_clk;

    // Offers one block, with a random gap before each burst, and returns at the
    // edge where the beat is taken. Ready is sampled on the falling edge.
    task automatic send_block(input logic [63:0] aw, input logic [63:0] cw);
        bit taken;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                blk.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        blk.valid      <= 1'b1;
        blk.alpha_word <= aw;
        blk.color_word <= cw;
        do begin
            @(negedge i_clk);
            taken = blk.ready;
            @(posedge i_clk);
        end while (!taken);
    endtask

    // Stops sending and waits until every predicted pixel has come out.
    task automatic wait_drained();
        blk.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    task automatic write_format(input t_fmt fmt);
        wait_drained();
        repeat (4) @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= fmt;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    // Endpoint extremes, both colour tables, both alpha tables with every
    // alpha index, a nibble ramp and equal endpoints.
    task automatic send_directed_blocks();
        send_block(64'h0, 64'h0);
        send_block('1, '1);
        send_block({48'o7654321076543210, 8'h00, 8'hFF}, {32'hE4E4E4E4, 16'h0000, 16'hFFFF});
        send_block({48'o0123456701234567, 8'hFF, 8'h00}, {32'h1B1B1B1B, 16'hF800, 16'h001F});
        send_block(64'hFEDCBA9876543210, {32'h55AA33CC, 16'h7BEF, 16'h7BEF});
    endtask

    // Pixel back-pressure: the pattern switches between modes every so often.
    initial begin
        t_rx_mode rx_mode;
        int       mode_left;
        int       hold;
        rx_mode   = RX_ALWAYS;
        mode_left = 0;
        hold      = 0;
        pix.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (mode_left == 0) begin
                rx_mode   = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 128);
            end
            mode_left--;
            case (rx_mode)
                RX_ALWAYS: pix.ready <= 1'b1;
                RX_MOSTLY: pix.ready <= ($urandom_range(0, 3) != 0);
                RX_RARELY: pix.ready <= ($urandom_range(0, 3) == 0);
                default: begin
                    if (hold == 0) begin
                        pix.ready <= 1'b1;
                        hold = $urandom_range(0, 12);
                    end else begin
                        pix.ready <= 1'b0;
                        hold--;
                    end
                end
            endcase
        end
    end

    // Stimulus: directed blocks in each format, then random phases.
    initial begin
        logic [63:0] rnd_alpha;
        logic [63:0] rnd_color;
        i_rst_n        <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_data       <= FMT_DXT1;
        blk.valid      <= 1'b0;
        blk.alpha_word <= '0;
        blk.color_word <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The reset format first, then each written one.
        send_directed_blocks();
        write_format(FMT_DXT3);
        send_directed_blocks();
        write_format(FMT_DXT5);
        send_directed_blocks();
        write_format(FMT_OTHER);
        send_directed_blocks();

        for (int phase = 0; phase < 8; phase++) begin
            write_format(phase == 0 ? FMT_DXT1 : t_fmt'($urandom_range(0, 3)));
            for (int n = 0; n < 19; n++) begin
                if (phase == 3 && n == 10)
                    wait_drained();
                rnd_alpha = {$urandom, $urandom};
                rnd_color = {$urandom, $urandom};
                // Equal endpoints reach the three-colour and fifths tables more often.
                if ($urandom_range(0, 7) == 0)
                    rnd_color[31:16] = rnd_color[15:0];
                if ($urandom_range(0, 7) == 0)
                    rnd_alpha[15:8] = rnd_alpha[7:0];
                send_block(rnd_alpha, rnd_color);
            end
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
